FILE: sv/source_text_cleaner_assert.svh
// Assertion macros used by the source text cleaner checker.
`ifndef SOURCE_TEXT_CLEANER_ASSERT_SVH
`define SOURCE_TEXT_CLEANER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define STC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("source_text_cleaner: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define STC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("source_text_cleaner: assertion failed");

`endif

FILE: sv/stc_pkg.sv
// Types, constants and per-byte step logic of the source text cleaner.
package stc_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Scanner comment mode
  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_BLOCK = 2'd2
  } cln_mode_t;

  // Scanner state carried from byte to byte
  typedef struct packed {
    cln_mode_t  mode;        // text, line comment, block comment
    logic       pend_v;      // a slash or star is held as lookahead
    logic       prev_slash;  // raw byte before the judged one was a slash
    logic       lhc;         // current output line already has content
  } cln_state_t;

  // Working set of one step: state plus up to two emitted bytes
  typedef struct packed {
    cln_state_t st;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } cln_work_t;

  // One result word as it sits in the output queue
  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       last;
  } out_word_t;

  localparam cln_state_t STATE_RESET = '{mode: MODE_TEXT, pend_v: 1'b0,
                                         prev_slash: 1'b0, lhc: 1'b0};

  // Append a byte; a third byte of a step is never delivered
  function automatic cln_work_t emit(cln_work_t w, logic [7:0] b);
    cln_work_t r;
    r = w;
    if (w.cnt == 2'd0) begin
      r.b0  = b;
      r.cnt = 2'd1;
    end else if (w.cnt == 2'd1) begin
      r.b1  = b;
      r.cnt = 2'd2;
    end
    return r;
  endfunction

  // Semicolon to newline, leading spaces and empty lines dropped
  function automatic cln_work_t put_clean(cln_work_t w, logic [7:0] b_in);
    cln_work_t r;
    logic [7:0] b;
    r = w;
    b = (b_in == CH_SEMI) ? CH_NL : b_in;
    if (b == CH_NL) begin
      if (w.st.lhc) begin
        r = emit(r, CH_NL);
        r.st.lhc = 1'b0;
      end
    end else if (!(b == CH_SPACE && !w.st.lhc)) begin
      r = emit(r, b);
      r.st.lhc = 1'b1;
    end
    return r;
  endfunction

  // Feed one raw byte: judge held lookahead first, then take the byte
  function automatic cln_work_t feed(cln_work_t w, logic [7:0] c);
    cln_work_t r;
    logic consumed;
    r = w;
    consumed = 1'b0;
    if (w.st.pend_v) begin
      r.st.pend_v = 1'b0;
      unique case (w.st.mode)
        MODE_LINE: begin
          if (c == CH_SLASH) begin
            r.st.mode = MODE_TEXT;
            consumed  = 1'b1;
          end
          r.st.prev_slash = 1'b1;
        end
        MODE_BLOCK: begin
          if (c == CH_SLASH) begin
            r.st.mode       = MODE_TEXT;
            r.st.prev_slash = 1'b1;
            consumed        = 1'b1;
          end else begin
            r.st.prev_slash = 1'b0;
          end
        end
        default: begin
          if (c == CH_SLASH) begin
            r.st.mode       = MODE_LINE;
            r.st.prev_slash = 1'b1;
            consumed        = 1'b1;
          end else if (c == CH_STAR) begin
            r.st.mode       = MODE_BLOCK;
            r.st.prev_slash = 1'b0;
            consumed        = 1'b1;
          end else begin
            r = put_clean(r, CH_SLASH);
            r.st.prev_slash = 1'b1;
          end
        end
      endcase
    end
    if (!consumed) begin
      unique case (r.st.mode)
        MODE_LINE: begin
          if (c == CH_SLASH && !r.st.prev_slash) begin
            r.st.pend_v = 1'b1;
          end else begin
            if (c == CH_NL) begin
              r.st.mode = MODE_TEXT;
              r = put_clean(r, CH_NL);
            end
            r.st.prev_slash = (c == CH_SLASH);
          end
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) begin
            r.st.pend_v = 1'b1;
          end else begin
            r.st.prev_slash = (c == CH_SLASH);
          end
        end
        default: begin
          r.st.mode = MODE_TEXT;
          if (c == CH_SLASH) begin
            r.st.pend_v = 1'b1;
          end else begin
            r = put_clean(r, c);
            r.st.prev_slash = 1'b0;
          end
        end
      endcase
    end
    return r;
  endfunction

endpackage

FILE: sv/stc_outq.sv
// Four-word result queue: takes up to two words per cycle, gives one.
module stc_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt,
  input  stc_pkg::out_word_t push0,
  input  stc_pkg::out_word_t push1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output stc_pkg::out_word_t out_word
);

  stc_pkg::out_word_t mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_word  = mem[rd_ptr_r];
  assign room      = (cnt_r <= 3'd2);
  assign pop       = out_valid && out_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_cnt;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    cnt_nxt    = cnt_r + {1'b0, push_cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Word storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_r + 2'd1] <= push1;
    end
  end

endmodule

FILE: sv/source_text_cleaner.sv
// Source text cleaner top level: input register, per-byte step logic, result queue.
// Raw text enters one byte per word; the cleaned text leaves one byte per word.
// An input word is held in the input register, where the comment,
// semicolon, leading-space and empty-line rules are applied to it in a single
// pass, and its zero to two result words go into a four-word queue, from which
// the results are offered on the output port. A new input word is
// taken every cycle while the queue has room for two words, so the sustained
// rate is one input word per cycle, bounded by the output port's one word per
// cycle when items produce two results. The word marked in_last closes the
// text: its final result carries out_last (a word with out_char_valid low if
// nothing else is left), and the scanner state returns to its reset value.
module source_text_cleaner (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  output logic       out_char_valid,
  output logic       out_last
);

  logic                 in_v_r;
  logic [7:0]           char_r;
  logic                 last_r;
  stc_pkg::cln_state_t  st_r, st_nxt;
  stc_pkg::cln_work_t   w0, w1, wf;
  stc_pkg::out_word_t   push0, push1, q_word;
  logic [1:0]           push_cnt;
  logic                 room;
  logic                 fire;

  assign fire     = in_v_r && room;
  assign in_ready = !in_v_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char_in;
      last_r <= in_last;
    end
  end

  // Step logic: the byte, then at end of text an implied closing newline unless a block comment is open
  always_comb begin
    w0     = '0;
    w0.st  = st_r;
    w1     = stc_pkg::feed(w0, char_r);
    wf     = w1;
    if (last_r) begin
      if (w1.st.mode == stc_pkg::MODE_BLOCK) begin
        wf.st.pend_v = 1'b0;
      end else begin
        wf = stc_pkg::feed(w1, stc_pkg::CH_NL);
      end
    end
    st_nxt = last_r ? stc_pkg::STATE_RESET : wf.st;
  end

  // Result words for the queue
  always_comb begin
    push0 = '{char_out: wf.b0, char_valid: 1'b1, last: 1'b0};
    push1 = '{char_out: wf.b1, char_valid: 1'b1, last: last_r};
    push_cnt = 2'd0;
    if (fire) begin
      push_cnt = wf.cnt;
      if (last_r && wf.cnt == 2'd0) begin
        push0    = '{char_out: 8'h00, char_valid: 1'b0, last: 1'b1};
        push_cnt = 2'd1;
      end else if (wf.cnt == 2'd1) begin
        push0.last = last_r;
      end
    end
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= stc_pkg::STATE_RESET;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  stc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (q_word)
  );

  assign out_char_out   = q_word.char_out;
  assign out_char_valid = q_word.char_valid;
  assign out_last       = q_word.last;

endmodule

FILE: sv/stc_checker.sv
// Port-level checker for the source text cleaner and its bind.
`include "source_text_cleaner_assert.svh"

module stc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_out,
  input logic       out_char_valid,
  input logic       out_last
);

  logic       out_byte;
  logic       out_stall;
  logic [9:0] out_bits;

  assign out_byte  = out_valid && out_char_valid;
  assign out_stall = out_valid && !out_ready;
  assign out_bits  = {out_char_out, out_char_valid, out_last};

  // An empty word only ever closes a text
  `STC_ASSERT_NOW(a_marker_is_last, clk, rst_n, out_valid && !out_char_valid, out_last)

  // Semicolons never reach the output
  `STC_ASSERT_NOW(a_no_semicolon, clk, rst_n, out_byte, out_char_out != stc_pkg::CH_SEMI)

  // A stalled result word holds
  `STC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_bits))

endmodule

bind source_text_cleaner stc_checker u_stc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_char_out   (out_char_out),
  .out_char_valid (out_char_valid),
  .out_last       (out_last)
);

FILE: test/testbench.sv
// Self-checking testbench for the source text cleaner: directed table, then random texts.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_WORDS = 1650;
  localparam int IDLE_LIMIT   = 3000;
  localparam int LONG_HOLD    = 400;

  // One cleaned word as the result port presents it
  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic       fin;
  } clean_word_t;

  // One row of stimulus; expectations typed in only where given is set
  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic        given;
    logic [1:0]  n;
    clean_word_t w0;
    clean_word_t w1;
  } stim_row_t;

  localparam clean_word_t NO_WORD  = '0;
  localparam clean_word_t END_MARK = '{ch: 8'h00, vld: 1'b0, fin: 1'b1};

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_in = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char_out;
  logic       out_char_valid;
  logic       out_last;

  source_text_cleaner DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_in     (in_char_in),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_out   (out_char_out),
    .out_char_valid (out_char_valid),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  clean_word_t expected_words[$];
  clean_word_t step_words[$];
  logic [7:0]  text_bytes[$];
  stim_row_t   dir_rows[25];
  int          words_in = 0;
  int          words_out = 0;
  int          bad_words = 0;
  logic        tx_calm = 1'b0;
  logic        rx_calm = 1'b0;
  logic        long_hold_done = 1'b0;
  logic        pause_done = 1'b0;

  // Scanner copy used for prediction
  logic [1:0] scan_mode = stc_pkg::MODE_TEXT;
  logic       held_v = 1'b0;
  logic       after_slash = 1'b0;
  logic       line_busy = 1'b0;
  logic [7:0] step_bytes[3];
  int         step_n = 0;

  // Queue appends
  function automatic void add_text_byte(logic [7:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  function automatic void add_expected(clean_word_t w);
    expected_words = {expected_words, w};
  endfunction

  function automatic void add_step_word(clean_word_t w);
    step_words = {step_words, w};
  endfunction

  function automatic void put_byte(logic [7:0] b);
    if (step_n < 3) begin
      step_bytes[step_n] = b;
      step_n++;
    end
  endfunction

  // Semicolon becomes newline; leading spaces and empty lines vanish
  function automatic void clean_byte(logic [7:0] raw);
    logic [7:0] b;
    b = (raw == stc_pkg::CH_SEMI) ? stc_pkg::CH_NL : raw;
    if (b == stc_pkg::CH_NL) begin
      if (line_busy) begin
        put_byte(stc_pkg::CH_NL);
        line_busy = 1'b0;
      end
    end else if (!(b == stc_pkg::CH_SPACE && !line_busy)) begin
      put_byte(b);
      line_busy = 1'b1;
    end
  endfunction

  // Decide what the held slash or star was, given the next byte
  function automatic logic judge_held(logic [7:0] c);
    logic taken;
    taken = 1'b0;
    held_v = 1'b0;
    if (scan_mode == stc_pkg::MODE_LINE) begin
      after_slash = 1'b1;
      if (c == stc_pkg::CH_SLASH) begin
        scan_mode = stc_pkg::MODE_TEXT;
        taken = 1'b1;
      end
    end else if (scan_mode == stc_pkg::MODE_BLOCK) begin
      if (c == stc_pkg::CH_SLASH) begin
        scan_mode = stc_pkg::MODE_TEXT;
        after_slash = 1'b1;
        taken = 1'b1;
      end else begin
        after_slash = 1'b0;
      end
    end else if (c == stc_pkg::CH_SLASH) begin
      scan_mode = stc_pkg::MODE_LINE;
      after_slash = 1'b1;
      taken = 1'b1;
    end else if (c == stc_pkg::CH_STAR) begin
      scan_mode = stc_pkg::MODE_BLOCK;
      after_slash = 1'b0;
      taken = 1'b1;
    end else begin
      clean_byte(stc_pkg::CH_SLASH);
      after_slash = 1'b1;
    end
    return taken;
  endfunction

  function automatic void take_byte(logic [7:0] c);
    if (scan_mode == stc_pkg::MODE_LINE) begin
      if (c == stc_pkg::CH_SLASH && !after_slash) begin
        held_v = 1'b1;
      end else begin
        if (c == stc_pkg::CH_NL) begin
          scan_mode = stc_pkg::MODE_TEXT;
          clean_byte(stc_pkg::CH_NL);
        end
        after_slash = (c == stc_pkg::CH_SLASH);
      end
    end else if (scan_mode == stc_pkg::MODE_BLOCK) begin
      if (c == stc_pkg::CH_STAR) held_v = 1'b1;
      else after_slash = (c == stc_pkg::CH_SLASH);
    end else begin
      scan_mode = stc_pkg::MODE_TEXT;
      if (c == stc_pkg::CH_SLASH) begin
        held_v = 1'b1;
      end else begin
        clean_byte(c);
        after_slash = 1'b0;
      end
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    logic taken;
    taken = 1'b0;
    if (held_v) taken = judge_held(c);
    if (!taken) take_byte(c);
  endfunction

  // Cleaned words caused by one raw byte; closes the text on the final byte
  function automatic void predict_clean(logic [7:0] c, logic fin);
    clean_word_t cw;
    step_n = 0;
    step_words.delete();
    scan_byte(c);
    if (fin) begin
      // unclosed block comment is dropped, otherwise a newline is implied
      if (scan_mode == stc_pkg::MODE_BLOCK) held_v = 1'b0;
      else scan_byte(stc_pkg::CH_NL);
      if (step_n > 2) step_n = 2;
    end
    for (int k = 0; k < step_n; k++) begin
      cw = '{ch: step_bytes[k], vld: 1'b1, fin: fin && (k == step_n - 1)};
      add_step_word(cw);
    end
    if (fin) begin
      if (step_n == 0) add_step_word(END_MARK);
      scan_mode = stc_pkg::MODE_TEXT;
      held_v = 1'b0;
      after_slash = 1'b0;
      line_busy = 1'b0;
    end
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 16) return stc_pkg::CH_SLASH;
    if (r < 26) return stc_pkg::CH_STAR;
    if (r < 34) return stc_pkg::CH_SEMI;
    if (r < 42) return stc_pkg::CH_NL;
    if (r < 56) return stc_pkg::CH_SPACE;
    if (r < 88) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // Random text built from code, comments, blank lines and noise
  task automatic build_text();
    int frags;
    int len;
    text_bytes.delete();
    frags = $urandom_range(1, 6);
    repeat (frags) begin
      len = $urandom_range(0, 7);
      case ($urandom_range(0, 9)) inside
        [0:2]: begin
          repeat (len + 1) begin
            case ($urandom_range(0, 5))
              0: add_text_byte(stc_pkg::CH_SPACE);
              1: add_text_byte(stc_pkg::CH_SEMI);
              default: add_text_byte(8'h61 + 8'($urandom_range(0, 25)));
            endcase
          end
        end
        [3:4]: begin
          add_text_byte(stc_pkg::CH_SLASH);
          add_text_byte(stc_pkg::CH_SLASH);
          repeat (len) add_text_byte(rand_char());
          if ($urandom_range(0, 4) != 0) add_text_byte(stc_pkg::CH_NL);
        end
        [5:6]: begin
          add_text_byte(stc_pkg::CH_SLASH);
          add_text_byte(stc_pkg::CH_STAR);
          repeat (len) add_text_byte(rand_char());
          if ($urandom_range(0, 6) != 0) begin
            add_text_byte(stc_pkg::CH_STAR);
            add_text_byte(stc_pkg::CH_SLASH);
          end
        end
        7: begin
          repeat (len) add_text_byte(stc_pkg::CH_SPACE);
          add_text_byte(stc_pkg::CH_NL);
        end
        default: begin
          repeat (len + 1) add_text_byte(rand_char());
        end
      endcase
    end
  endtask

  // Offer one word, hold it until taken, then record what it should produce
  task automatic send_word(input stim_row_t row);
    int gap;
    in_valid   <= 1'b1;
    in_char_in <= row.ch;
    in_last    <= row.fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_clean(row.ch, row.fin);
    if (row.given) begin
      if (row.n > 0) add_expected(row.w0);
      if (row.n > 1) add_expected(row.w1);
    end else begin
      foreach (step_words[k]) add_expected(step_words[k]);
    end
    words_in++;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 2) == 0) gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed table, then random texts
  initial begin
    stim_row_t row;
    dir_rows = '{
      '{"a", 1'b1, 1'b1, 2'd2, '{"a", 1'b1, 1'b0}, '{stc_pkg::CH_NL, 1'b1, 1'b1}},
      '{stc_pkg::CH_SPACE, 1'b1, 1'b1, 2'd1, END_MARK, NO_WORD},  // blank text
      '{8'hFF, 1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NO_WORD},
      '{8'h00, 1'b0, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0}, NO_WORD},
      '{stc_pkg::CH_SEMI, 1'b0, 1'b1, 2'd1, '{stc_pkg::CH_NL, 1'b1, 1'b0}, NO_WORD},
      '{stc_pkg::CH_SEMI, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},    // empty line
      '{stc_pkg::CH_SPACE, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},   // leading space
      '{stc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{stc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{"q", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{stc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{stc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},   // closes line comment
      '{"z", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{stc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{stc_pkg::CH_STAR, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{stc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},   // slash-star-slash stays open
      '{stc_pkg::CH_NL, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{stc_pkg::CH_STAR, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{stc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{"b", 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{stc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{"c", 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},                 // crowded end
      '{stc_pkg::CH_SLASH, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{stc_pkg::CH_STAR, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
      '{"x", 1'b1, 1'b1, 2'd1, END_MARK, NO_WORD}                 // unclosed block
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_word(dir_rows[i]);
    in_valid <= 1'b0;
    drain_results();

    while (words_in < RANDOM_WORDS + 25) begin
      build_text();
      tx_calm = ($urandom_range(0, 3) == 0);
      // one pause mid-run until the result side has caught up
      if (!pause_done && words_in >= 900) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        drain_results();
      end
      foreach (text_bytes[i]) begin
        row = '{text_bytes[i], (i == text_bytes.size() - 1), 1'b0, 2'd0, NO_WORD, NO_WORD};
        send_word(row);
      end
    end
    in_valid <= 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (bad_words == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Result side back-pressure, plus one long hold-off to fill the block
  initial begin
    int stall_left;
    int rx_cycles;
    logic rdy;
    stall_left = 0;
    rx_cycles = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_cycles % 128 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (stall_left != 0) begin
        rdy = 1'b0;
        stall_left--;
      end else if (!long_hold_done && words_out >= 300) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD - 1;
        rdy = 1'b0;
      end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
        stall_left = idle_len() - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
      @(posedge clk);
      rx_cycles++;
    end
  end

  // Compare each delivered word with the oldest prediction
  initial begin
    clean_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        words_out++;
        if (expected_words.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("unexpected word: char %02h valid %0b last %0b",
                     out_char_out, out_char_valid, out_last);
        end else begin
          want = expected_words.pop_front();
          if (out_char_out !== want.ch || out_char_valid !== want.vld ||
              out_last !== want.fin) begin
            bad_words++;
            if (bad_words <= 10)
              $display("mismatch: expected char %02h valid %0b last %0b, got %02h %0b %0b",
                       want.ch, want.vld, want.fin, out_char_out, out_char_valid, out_last);
          end
        end
      end
    end
  end

  // Watchdog: ends the run after too long without any handshake
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

endmodule
